@@ rtl/core/lsh_pkg.sv @@
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types, constants and the bucket threshold table of the
// logarithmic bucket histogram.
// ----------------------------------------------------------------------------
package lsh_pkg;

  localparam int NUM_BUCKETS_DEF  = 256;
  localparam int COUNTER_BITS_DEF = 32;

  // threshold table geometry
  localparam int THR_DEPTH = 256;
  localparam int THR_IDX_W = $clog2(THR_DEPTH);
  localparam int SRCH_W    = $clog2(THR_DEPTH + 1);
  localparam int DIG_CAP   = 260;
  localparam logic [63:0] THR_SAT = 64'd1 << 40;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] sample_value;
    logic [7:0]  read_bucket;
  } req_t;

  typedef struct packed {
    logic [7:0]  bucket_index;
    logic [31:0] bucket_count;
    logic [31:0] total_count;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic search_step;
    logic set_bucket;
    logic clear_wr;
    logic rd_issue;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_read;
    logic search_done;
    logic clear_done;
  } ctrl_sts_t;

  // bit 32 marks a threshold that no 32-bit sample reaches
  typedef logic [THR_DEPTH-1:0][32:0] thr_table_t;

  // thresholds ceil(1.1^k - 1.1), from 11^k kept as decimal digits
  function automatic thr_table_t thr_build();
    thr_table_t               tab;
    logic [DIG_CAP-1:0][3:0]  dig;
    int                       len;
    int                       carry;
    int                       v;
    logic [63:0]              ip;
    logic [63:0]              t;
    logic                     above;
    logic                     done;
    tab    = '1;
    dig    = '0;
    dig[0] = 4'd1;
    len    = 1;
    done   = 1'b0;
    for (int j = 0; j < THR_DEPTH; j++) begin
      if (!done) begin
        ip = '0;
        for (int i = DIG_CAP; i > 0; i--) begin
          if (i <= len && i > j) begin
            ip = ip * 64'd10 + 64'(dig[i-1]);
            if (ip > THR_SAT) ip = THR_SAT;
          end
        end
        above = 1'b0;
        if (j >= 1) begin
          if (dig[j-1] > 4'd1) begin
            above = 1'b1;
          end else if (dig[j-1] == 4'd1) begin
            for (int i = 0; i < DIG_CAP; i++) begin
              if (i + 1 < j && dig[i] != 4'd0) above = 1'b1;
            end
          end
        end
        if (above) t = ip;
        else if (ip > 64'd0) t = ip - 64'd1;
        else t = '0;
        if (t > 64'h0000_0000_FFFF_FFFF) begin
          done = 1'b1;
        end else begin
          tab[j] = {1'b0, t[31:0]};
        end
        carry = 0;
        for (int i = 0; i < DIG_CAP; i++) begin
          if (i < len) begin
            v      = int'(dig[i]) * 11 + carry;
            dig[i] = 4'(v % 10);
            carry  = v / 10;
          end
        end
        for (int i = 0; i < DIG_CAP; i++) begin
          if (carry != 0 && i == len) begin
            dig[i] = 4'(carry % 10);
            carry  = carry / 10;
            len    = len + 1;
          end
        end
      end
    end
    return tab;
  endfunction

  localparam thr_table_t THR_TABLE = thr_build();

endpackage

@@ rtl/core/lsh_ram.sv @@
// ----------------------------------------------------------------------------
// lsh_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/lsh_datapath.sv @@
// ----------------------------------------------------------------------------
// lsh_datapath
// Threshold binary search, bucket counter store with saturating update,
// total count and the result register.
// ----------------------------------------------------------------------------
module lsh_datapath import lsh_pkg::*; #(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  ctrl_cmd_t cmd,
  output ctrl_sts_t sts,
  output rsp_t      rsp
);

  localparam int AW       = $clog2(NUM_BUCKETS);
  localparam int SRCH_LIM = (NUM_BUCKETS < THR_DEPTH) ? NUM_BUCKETS : THR_DEPTH;
  localparam logic [AW-1:0] LAST_BUCKET = AW'(NUM_BUCKETS - 1);

  logic                    is_read;
  logic [31:0]             sample;
  logic                    in_range;
  logic [7:0]              index8;
  logic [AW-1:0]           bucket;
  logic [SRCH_W-1:0]       lo;
  logic [SRCH_W-1:0]       hi;
  logic [AW-1:0]           clr_addr;
  logic [COUNTER_BITS-1:0] total;

  logic [SRCH_W:0]         mid_sum;
  logic [SRCH_W-1:0]       mid;
  logic [32:0]             thr;
  logic                    thr_le;
  logic [AW-1:0]           bucket_next;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [COUNTER_BITS-1:0] wr_data;
  logic [COUNTER_BITS-1:0] rd_data;
  logic [COUNTER_BITS-1:0] cnt_inc;
  logic [COUNTER_BITS-1:0] total_inc;

  // search step
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[SRCH_W:1];
  assign thr     = THR_TABLE[mid[THR_IDX_W-1:0]];
  assign thr_le  = !thr[32] && (thr[31:0] <= sample);

  always_comb begin
    if (sample == 32'd0) begin
      bucket_next = '0;
    end else if (32'(lo) > 32'(NUM_BUCKETS - 1)) begin
      bucket_next = LAST_BUCKET;
    end else begin
      bucket_next = AW'(lo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      is_read  <= (req.op == OP_READ);
      sample   <= req.sample_value;
      index8   <= req.read_bucket;
      bucket   <= AW'(req.read_bucket);
      in_range <= (32'(req.read_bucket) < 32'(NUM_BUCKETS));
      lo       <= '0;
      hi       <= SRCH_W'(SRCH_LIM);
    end else if (cmd.search_step) begin
      if (thr_le) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end else if (cmd.set_bucket) begin
      bucket <= bucket_next;
      index8 <= 8'(bucket_next);
    end
  end

  // counter store
  assign cnt_inc   = (rd_data == '1) ? rd_data : rd_data + 1'b1;
  assign total_inc = (total == '1) ? total : total + 1'b1;
  assign wr_en     = cmd.clear_wr || (cmd.commit && !is_read);
  assign wr_addr   = cmd.clear_wr ? clr_addr : bucket;
  assign wr_data   = cmd.clear_wr ? '0 : cnt_inc;

  lsh_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (NUM_BUCKETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (bucket),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      total    <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.commit && !is_read) begin
        total <= total_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.bucket_index <= index8;
      if (is_read) begin
        rsp.bucket_count <= in_range ? 32'(rd_data) : 32'd0;
        rsp.total_count  <= 32'(total);
      end else begin
        rsp.bucket_count <= 32'(cnt_inc);
        rsp.total_count  <= 32'(total_inc);
      end
    end
  end

  assign sts.req_read    = (req.op == OP_READ);
  assign sts.search_done = (lo == hi);
  assign sts.clear_done  = (clr_addr == LAST_BUCKET);

endmodule

@@ rtl/core/lsh_ctrl.sv @@
// ----------------------------------------------------------------------------
// lsh_ctrl
// Sequencer for the histogram: clearing pass, request intake, threshold
// search, counter fetch and commit of the result.
// ----------------------------------------------------------------------------
module lsh_ctrl import lsh_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_FETCH  = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = sts.req_read ? ST_FETCH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          cmd.set_bucket = 1'b1;
          state_next     = ST_FETCH;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      ST_FETCH: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign req_stall = (state != ST_IDLE);

endmodule

@@ rtl/core/log_scale_histogram.sv @@
// ----------------------------------------------------------------------------
// log_scale_histogram
// Latency histogram with logarithmic buckets: adds samples, reads counters.
// ----------------------------------------------------------------------------
// add: up to $clog2(min(NUM_BUCKETS,256)+1) binary search steps over the threshold
//   table (9 at 256 buckets), then one counter ram read and the commit
// read: one counter ram read then commit
// a new request is taken only in the cycle after the previous one commits
// after reset the counter ram is cleared, one entry a cycle, while req_stall is high
module log_scale_histogram import lsh_pkg::*; #(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  lsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsh_datapath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

@@ rtl/core/lsh_checker.sv @@
// ----------------------------------------------------------------------------
// lsh_checker
// Port level checks of the histogram, bound to the top level.
// ----------------------------------------------------------------------------
module lsh_checker import lsh_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  logic [2:0]  pending;
  logic [31:0] last_total;
  logic        req_take;
  logic        rsp_take;

  assign req_take = req_valid && !req_stall;
  assign rsp_take = rsp_valid && !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      last_total <= '0;
    end else begin
      pending <= pending + 3'(req_take) - 3'(rsp_take);
      if (rsp_take) begin
        last_total <= rsp.total_count;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("rsp_valid dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("rsp changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 3'd0)
    else $error("response without an open transaction");

  a_total_mono: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.total_count >= last_total)
    else $error("total count went down");

  a_count_total: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.bucket_count != 32'd0 |-> rsp.total_count != 32'd0)
    else $error("nonzero bucket with zero total");

endmodule

bind log_scale_histogram lsh_checker u_lsh_checker (.*);

@@ tb/sv/hist_checker.sv @@
// ----------------------------------------------------------------------------
// hist_checker
// Watches both channels of the logarithmic bucket histogram. It predicts each
// response from its own bucket counters and an exact threshold table, then
// compares the responses field by field, in order.
// ----------------------------------------------------------------------------
module hist_checker import lsh_pkg::*; #(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);

  localparam int WIDE = 1024;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  logic [31:0]             threshold [NUM_BUCKETS];
  int                      num_thresholds;
  logic [COUNTER_BITS-1:0] bin_count [NUM_BUCKETS];
  logic [COUNTER_BITS-1:0] sample_sum;
  rsp_t                    expected_rsps [$];

  // ceil(1.1^k - 1.1) = ceil((11^k - 11 * 10^(k-1)) / 10^k), exact big integers
  function automatic void build_thresholds();
    logic [WIDE-1:0] pow11;
    logic [WIDE-1:0] pow10;
    logic [WIDE-1:0] num;
    logic [WIDE-1:0] t;
    pow11 = 1;
    pow10 = 1;
    num_thresholds = 0;
    for (int k = 0; k < NUM_BUCKETS; k++) begin
      if (k == 0) begin
        t = '0;
      end else begin
        num = pow11 - (pow10 / 10) * 11;
        t   = (num + pow10 - 1) / pow10;
      end
      if (t > 32'hFFFF_FFFF) break;
      threshold[k]   = t[31:0];
      num_thresholds = k + 1;
      pow11 = pow11 * 11;
      pow10 = pow10 * 10;
    end
  endfunction

  function automatic int bucket_for_sample(logic [31:0] s);
    int cnt;
    cnt = 0;
    if (s == 32'd0) return 0;
    for (int k = 0; k < num_thresholds; k++)
      if (threshold[k] <= s) cnt++;
    if (cnt > NUM_BUCKETS - 1) cnt = NUM_BUCKETS - 1;
    return cnt;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t p;
    int   b;
    if (r.op == OP_ADD) begin
      b = bucket_for_sample(r.sample_value);
      if (bin_count[b] != CNT_MAX) bin_count[b] = bin_count[b] + 1'b1;
      if (sample_sum != CNT_MAX) sample_sum = sample_sum + 1'b1;
      p.bucket_count = 32'(bin_count[b]);
    end else begin
      b = int'(r.read_bucket);
      p.bucket_count = (b < NUM_BUCKETS) ? 32'(bin_count[b]) : 32'd0;
    end
    p.bucket_index = 8'(b);
    p.total_count  = 32'(sample_sum);
    return p;
  endfunction

  function automatic bit field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v === act_v) return 1'b1;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    return 1'b0;
  endfunction

  initial build_thresholds();

  always @(posedge clk) begin
    rsp_t want;
    bit   ok;
    if (rst) begin
      expected_rsps.delete();
      sample_sum = '0;
      foreach (bin_count[i]) bin_count[i] = '0;
      errors = 0;
    end else begin
      // compare before predicting: no response is seen in the same cycle that its request is taken
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, index %0d count %0d total %0d",
                   $time, rsp.bucket_index, rsp.bucket_count, rsp.total_count);
        end else begin
          want = expected_rsps.pop_front();
          ok   = field_ok("bucket_index", 32'(want.bucket_index), 32'(rsp.bucket_index));
          ok   = field_ok("bucket_count", want.bucket_count, rsp.bucket_count) && ok;
          ok   = field_ok("total_count", want.total_count, rsp.total_count) && ok;
          if (!ok) errors++;
        end
      end
      if (req_valid && !req_stall) expected_rsps.push_back(apply_request(req));
    end
    pending = expected_rsps.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives the logarithmic bucket histogram with directed and random adds and
// reads, with random gaps and stalls on both sides; hist_checker predicts and
// compares every response.
// ----------------------------------------------------------------------------
module testbench;
  import lsh_pkg::*;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   errors;
  int   pending;
  bit   req_quiet;
  bit   rsp_quiet;

  always #6 clk = ~clk;

  log_scale_histogram i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  hist_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending)
  );

  task automatic send(input req_t r);
    int gap;
    gap = req_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!(req_valid === 1'b1 && req_stall === 1'b0));
    @(negedge clk);
  endtask

  task automatic add_sample(input logic [31:0] v);
    req_t r;
    r.op           = OP_ADD;
    r.sample_value = v;
    r.read_bucket  = 8'($urandom);
    send(r);
  endtask

  task automatic read_count(input logic [7:0] b);
    req_t r;
    r.op           = OP_READ;
    r.sample_value = $urandom;
    r.read_bucket  = b;
    send(r);
  endtask

  // sample close to threshold k, the lower edge of bucket k + 1
  task automatic add_near(input int k, input int off);
    longint x;
    x = longint'($ceil(1.1 ** real'(k) - 1.1)) + off;
    if (x < 0) x = 0;
    if (x > 64'h0000_0000_FFFF_FFFF) x = 64'h0000_0000_FFFF_FFFF;
    add_sample(x[31:0]);
  endtask

  initial begin
    int wait_n;
    int taken;
    taken = 0;
    forever begin
      if (taken % 100 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
      wait_n = rsp_quiet ? 0 : $urandom_range(0, 10);
      if (wait_n > 0) begin
        rsp_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    int sel;
    int off;
    int w;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed: zero, smallest, largest, edges of a few buckets, reads
    read_count(8'd0);
    add_sample(32'd0);
    add_sample(32'd1);
    add_sample(32'd2);
    add_sample(32'hFFFF_FFFF);
    add_sample(32'h8000_0000);
    add_sample(32'h7FFF_FFFF);
    add_sample(32'hFFFF_FFFF);
    add_near(30, -1);
    add_near(30, 0);
    add_near(30, 1);
    add_near(120, 0);
    add_near(233, 0);
    add_near(233, -1);
    read_count(8'd0);
    read_count(8'd2);
    read_count(8'd255);
    read_count(8'd233);
    read_count(8'hAA);
    read_count(8'h55);

    for (int n = 0; n < 1300; n++) begin
      if (n % 100 == 0) req_quiet = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        off = $urandom_range(0, 4);
        add_near($urandom_range(0, 236), off - 2);
      end else if (sel < 65) begin
        w = $urandom_range(0, 32);
        add_sample((w == 0) ? 32'd0 : ($urandom >> (32 - w)));
      end else if (sel < 70) begin
        add_sample($urandom);
      end else begin
        read_count(8'($urandom));
      end
    end
    req_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/lsh_pkg.sv
rtl/core/lsh_ram.sv
rtl/core/lsh_datapath.sv
rtl/core/lsh_ctrl.sv
rtl/core/log_scale_histogram.sv
rtl/core/lsh_checker.sv
tb/sv/hist_checker.sv
tb/sv/testbench.sv
